// ===== hdl/smx_pkg.sv =====
// Shared types and constants for the stack machine execute unit.
// No dependencies; used by every module under hdl.
package smx_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int NUM_REGS_DEF    = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int DATA_W      = 32;
  localparam int ACTION_W    = 5;
  localparam int REG_IDX_W   = 4;
  localparam int TARGET_W    = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 9;

  localparam logic [ACTION_W-1:0] ACT_PUSH  = 5'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSHR = 5'd1;
  localparam logic [ACTION_W-1:0] ACT_POP   = 5'd2;
  localparam logic [ACTION_W-1:0] ACT_POPR  = 5'd3;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 5'd4;
  localparam logic [ACTION_W-1:0] ACT_SUB   = 5'd5;
  localparam logic [ACTION_W-1:0] ACT_MUL   = 5'd6;
  localparam logic [ACTION_W-1:0] ACT_DIV   = 5'd7;
  localparam logic [ACTION_W-1:0] ACT_OUT   = 5'd8;
  localparam logic [ACTION_W-1:0] ACT_IN    = 5'd9;
  localparam logic [ACTION_W-1:0] ACT_JMP   = 5'd10;
  localparam logic [ACTION_W-1:0] ACT_JEQ   = 5'd11;
  localparam logic [ACTION_W-1:0] ACT_JNE   = 5'd12;
  localparam logic [ACTION_W-1:0] ACT_JA    = 5'd13;
  localparam logic [ACTION_W-1:0] ACT_JAE   = 5'd14;
  localparam logic [ACTION_W-1:0] ACT_JB    = 5'd15;
  localparam logic [ACTION_W-1:0] ACT_JBE   = 5'd16;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOREG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd4;

  typedef enum logic [3:0] {
    CLS_PUSH,
    CLS_PUSHR,
    CLS_POP,
    CLS_POPR,
    CLS_ARITH,
    CLS_OUT,
    CLS_JMP,
    CLS_CJMP,
    CLS_NOP
  } op_class_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV
  } back_state_e;

  typedef struct packed {
    op_class_e                cls;
    logic [ACTION_W-1:0]      action;
    logic [DATA_W-1:0]        value;
    logic [REG_IDX_W-1:0]     reg_index;
    logic [TARGET_W-1:0]      jump_target;
  } smx_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     out_valid;
    logic [DATA_W-1:0]        out_value;
    logic                     branch_taken;
    logic [TARGET_W-1:0]      branch_target;
    logic [COUNT_OUT_W-1:0]   stack_count;
  } smx_result_t;

endpackage

// ===== hdl/smx_front.sv =====
// Front end: accepts instruction transactions, classifies the action and
// registers the decoded entry for the queue. Depends on smx_pkg.
module smx_front import smx_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ACTION_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0]    value_i,
  input  logic [REG_IDX_W-1:0]        reg_index_i,
  input  logic [TARGET_W-1:0]         jump_target_i,
  output logic                        entry_valid_o,
  output smx_entry_t                  entry_o,
  input  logic                        entry_ready_i
);

  logic       valid_q;
  smx_entry_t entry_q;
  smx_entry_t entry_d;
  op_class_e  cls;

  always_comb begin
    case (action_i) inside
      ACT_PUSH, ACT_IN:                  cls = CLS_PUSH;
      ACT_PUSHR:                         cls = CLS_PUSHR;
      ACT_POP:                           cls = CLS_POP;
      ACT_POPR:                          cls = CLS_POPR;
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: cls = CLS_ARITH;
      ACT_OUT:                           cls = CLS_OUT;
      ACT_JMP:                           cls = CLS_JMP;
      [ACT_JEQ:ACT_JBE]:                 cls = CLS_CJMP;
      default:                           cls = CLS_NOP;
    endcase
  end

  always_comb begin
    entry_d.cls         = cls;
    entry_d.action      = action_i;
    entry_d.value       = value_i;
    entry_d.reg_index   = reg_index_i;
    entry_d.jump_target = jump_target_i;
  end

  assign in_ready_o    = !valid_q || entry_ready_i;
  assign entry_valid_o = valid_q;
  assign entry_o       = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== hdl/smx_queue.sv =====
// Short FIFO of decoded entries between front and back end.
// Depends on smx_pkg for the entry type and depth.
module smx_queue import smx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  input  smx_entry_t wr_data_i,
  output logic       wr_ready_o,
  output logic       rd_valid_o,
  output smx_entry_t rd_data_o,
  input  logic       rd_ready_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  smx_entry_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]       wptr_q, rptr_q;
  logic [CW-1:0]       cnt_q;
  logic                do_wr, do_rd;

  assign wr_ready_o = cnt_q != CW'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/smx_divider.sv =====
// Signed 32-bit divider, truncating, one quotient bit per cycle.
// Depends on smx_pkg for the data width.
module smx_divider import smx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int NW = $clog2(DATA_W + 1);

  logic [NW-1:0]     cnt_q;
  logic              done_q;
  logic              neg_q;
  logic [DATA_W-1:0] dq_q, dv_q, rem_q;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              fits;

  assign rem_sh = {rem_q, dq_q[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dv_q};
  assign fits   = !diff[DATA_W+1];

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -dq_q : dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= NW'(DATA_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= cnt_q == NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      dq_q  <= dividend_i[DATA_W-1] ? -dividend_i : dividend_i;
      dv_q  <= divisor_i[DATA_W-1] ? -divisor_i : divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      dq_q  <= {dq_q[DATA_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/smx_back.sv =====
// Back end: stack memory, register file, execute sequencer and result register.
// Depends on smx_pkg and smx_divider.
module smx_back import smx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_REGS    = NUM_REGS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  smx_entry_t  entry_i,
  output logic        entry_ready_o,
  output logic        res_valid_o,
  output smx_result_t res_o,
  input  logic        res_ready_i
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rf_mem  [NUM_REGS];

  back_state_e       state_q, state_d;
  smx_entry_t        cur_q;
  logic [CW-1:0]     count_q, count_d;
  logic [NUM_REGS-1:0] written_q;
  logic [DATA_W-1:0] a_q, b_q, r_q;
  logic              res_valid_q;
  smx_result_t       res_q, res_d;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [RIW-1:0]    head_ri, cur_ri;
  logic              out_free, fetch, commit, div_start;
  logic              has1, has2, full, ri_in, reg_ok;
  logic              stk_we, rf_we;
  logic [DATA_W-1:0] stk_wd, arith_res, div_q;
  logic              div_done, cmp;

  assign cnt_m1   = count_q - 1'b1;
  assign cnt_m2   = count_q - CW'(2);
  assign head_ri  = RIW'(entry_i.reg_index);
  assign cur_ri   = RIW'(cur_q.reg_index);
  assign out_free = !res_valid_q || res_ready_i;

  assign has1   = count_q != '0;
  assign has2   = count_q > CW'(1);
  assign full   = count_q == CW'(STACK_DEPTH);
  assign ri_in  = int'(cur_q.reg_index) < NUM_REGS;
  assign reg_ok = ri_in && written_q[cur_ri];

  assign fetch         = (state_q == BK_IDLE) && entry_valid_i;
  assign entry_ready_o = state_q == BK_IDLE;

  always_comb begin
    case (cur_q.action)
      ACT_ADD: arith_res = a_q + b_q;
      ACT_SUB: arith_res = a_q - b_q;
      default: arith_res = DATA_W'(a_q * b_q);
    endcase
  end

  always_comb begin
    case (cur_q.action)
      ACT_JEQ: cmp = a_q == b_q;
      ACT_JNE: cmp = a_q != b_q;
      ACT_JA:  cmp = $signed(a_q) >  $signed(b_q);
      ACT_JAE: cmp = $signed(a_q) >= $signed(b_q);
      ACT_JB:  cmp = $signed(a_q) <  $signed(b_q);
      default: cmp = $signed(a_q) <= $signed(b_q);
    endcase
  end

  smx_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    commit    = 1'b0;
    div_start = 1'b0;
    stk_we    = 1'b0;
    rf_we     = 1'b0;
    stk_wd    = cur_q.value;
    res_d     = '0;
    res_d.status = ST_OK;
    case (state_q)
      BK_IDLE: begin
        if (fetch) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        case (cur_q.cls)
          CLS_PUSH: begin
            if (full) begin
              res_d.status = ST_OVER;
            end else begin
              stk_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CLS_PUSHR: begin
            stk_wd = r_q;
            if (!reg_ok) begin
              res_d.status = ST_NOREG;
            end else if (full) begin
              res_d.status = ST_OVER;
            end else begin
              stk_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CLS_POP: begin
            if (!has1) begin
              res_d.status = ST_UNDER;
            end else begin
              count_d = cnt_m1;
            end
          end
          CLS_POPR: begin
            if (!has1) begin
              res_d.status = ST_UNDER;
            end else if (!ri_in) begin
              res_d.status = ST_NOREG;
            end else begin
              rf_we   = 1'b1;
              count_d = cnt_m1;
            end
          end
          CLS_ARITH: begin
            stk_wd = arith_res;
            if (!has2) begin
              res_d.status = ST_UNDER;
            end else if (full) begin
              res_d.status = ST_OVER;
            end else if (cur_q.action == ACT_DIV && b_q == '0) begin
              res_d.status = ST_DIVZ;
            end else if (cur_q.action == ACT_DIV) begin
              div_start = 1'b1;
            end else begin
              stk_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CLS_OUT: begin
            if (!has1) begin
              res_d.status = ST_UNDER;
            end else begin
              res_d.out_valid = 1'b1;
              res_d.out_value = a_q;
              count_d         = cnt_m1;
            end
          end
          CLS_JMP: begin
            res_d.branch_taken  = 1'b1;
            res_d.branch_target = cur_q.jump_target;
          end
          CLS_CJMP: begin
            if (!has2) begin
              res_d.status = ST_UNDER;
            end else if (cmp) begin
              res_d.branch_taken  = 1'b1;
              res_d.branch_target = cur_q.jump_target;
            end
          end
          default: ;
        endcase
        if (div_start) begin
          stk_we  = 1'b0;
          count_d = count_q;
          state_d = BK_DIV;
        end else if (out_free) begin
          commit  = 1'b1;
          state_d = BK_IDLE;
        end else begin
          stk_we  = 1'b0;
          rf_we   = 1'b0;
          count_d = count_q;
        end
      end
      BK_DIV: begin
        stk_wd = div_q;
        if (div_done && out_free) begin
          commit  = 1'b1;
          stk_we  = 1'b1;
          count_d = count_q + 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    res_d.stack_count = COUNT_OUT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      written_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        count_q <= count_d;
      end
      if (commit && rf_we) begin
        written_q[cur_ri] <= 1'b1;
      end
      if (commit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
    if (fetch) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      a_q <= stk_mem[cnt_m1[AW-1:0]];
      b_q <= stk_mem[cnt_m2[AW-1:0]];
    end
    if (commit && stk_we) begin
      stk_mem[count_q[AW-1:0]] <= stk_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      r_q <= rf_mem[head_ri];
    end
    if (commit && rf_we) begin
      rf_mem[cur_ri] <= a_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == BK_DIV)
    else $error("divide start did not enter wait state");

  a_commit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (state_q == BK_EXEC || state_q == BK_DIV))
    else $error("commit outside execute");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status != ST_OK) |-> (!res_q.out_valid && !res_q.branch_taken))
    else $error("error result carries side outputs");

  a_fetch_loads_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch |=> (state_q == BK_EXEC && $stable(count_q)))
    else $error("fetch did not move to execute");

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Stack machine execute unit. Each instruction transaction is decoded by the
// front end, waits in a two-entry queue, and is executed by the back end,
// which first reads the two top stack words and the addressed register from
// their memories and then executes and writes back once the output register
// is free; div also waits for the bit-serial divider. Results go to an output
// register, and new instructions are still accepted into the queue while a
// result waits. The stack and register file need no clearing after reset.
// Depends on smx_pkg and the smx_* modules.
module stack_machine_execute_unit import smx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_REGS    = NUM_REGS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ACTION_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0]    value_i,
  input  logic [REG_IDX_W-1:0]        reg_index_i,
  input  logic [TARGET_W-1:0]         jump_target_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [STATUS_W-1:0]         status_o,
  output logic                        out_valid_o,
  output logic signed [DATA_W-1:0]    out_value_o,
  output logic                        branch_taken_o,
  output logic [TARGET_W-1:0]         branch_target_o,
  output logic [COUNT_OUT_W-1:0]      stack_count_o
);

  logic        fe_valid, fe_ready;
  smx_entry_t  fe_entry;
  logic        q_valid, q_ready;
  smx_entry_t  q_entry;
  smx_result_t res;

  smx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .reg_index_i   (reg_index_i),
    .jump_target_i (jump_target_i),
    .entry_valid_o (fe_valid),
    .entry_o       (fe_entry),
    .entry_ready_i (fe_ready)
  );

  smx_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_data_i  (fe_entry),
    .wr_ready_o (fe_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_entry),
    .rd_ready_i (q_ready)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_REGS    (NUM_REGS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_i       (q_entry),
    .entry_ready_o (q_ready),
    .res_valid_o   (result_valid_o),
    .res_o         (res),
    .res_ready_i   (result_ready_i)
  );

  assign status_o        = res.status;
  assign out_valid_o     = res.out_valid;
  assign out_value_o     = res.out_value;
  assign branch_taken_o  = res.branch_taken;
  assign branch_target_o = res.branch_target;
  assign stack_count_o   = res.stack_count;

endmodule

// ===== tb/smx_exec_checker.sv =====
// Transaction checker for stack_machine_execute_unit: predicts each result from
// the accepted instructions and compares it with what the unit returns.
// Depends on smx_pkg.
module smx_exec_checker import smx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_REGS    = NUM_REGS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [ACTION_W-1:0]      action_i,
  input  logic [DATA_W-1:0]        value_i,
  input  logic [REG_IDX_W-1:0]     reg_index_i,
  input  logic [TARGET_W-1:0]      jump_target_i,
  input  logic                     result_valid_i,
  input  logic                     result_ready_i,
  input  logic [STATUS_W-1:0]      status_i,
  input  logic                     out_valid_i,
  input  logic [DATA_W-1:0]        out_value_i,
  input  logic                     branch_taken_i,
  input  logic [TARGET_W-1:0]      branch_target_i,
  input  logic [COUNT_OUT_W-1:0]   stack_count_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  logic [DATA_W-1:0]   stack_words [STACK_DEPTH];
  int unsigned         stack_used;
  logic [DATA_W-1:0]   reg_words [NUM_REGS];
  logic [NUM_REGS-1:0] reg_valid;
  smx_result_t         exp_results_q [$];

  function automatic logic [DATA_W-1:0] alu_result(logic [ACTION_W-1:0] act,
                                                   logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b);
    longint sa;
    longint sb;
    longint quot;
    sa = $signed(a);
    sb = $signed(b);
    case (act)
      ACT_ADD: return a + b;
      ACT_SUB: return a - b;
      ACT_MUL: return a * b;
      default: begin
        quot = sa / sb;
        return quot[DATA_W-1:0];
      end
    endcase
  endfunction

  function automatic logic branch_cond(logic [ACTION_W-1:0] act,
                                       logic signed [DATA_W-1:0] a,
                                       logic signed [DATA_W-1:0] b);
    case (act)
      ACT_JEQ: return a == b;
      ACT_JNE: return a != b;
      ACT_JA:  return a > b;
      ACT_JAE: return a >= b;
      ACT_JB:  return a < b;
      default: return a <= b;
    endcase
  endfunction

  // updates the shadow stack and register file, returns the expected result
  function automatic smx_result_t execute_instr(logic [ACTION_W-1:0] act,
                                                logic [DATA_W-1:0] val,
                                                logic [REG_IDX_W-1:0] ri,
                                                logic [TARGET_W-1:0] tgt);
    smx_result_t res;
    logic [DATA_W-1:0] top_w;
    logic [DATA_W-1:0] next_w;
    int unsigned n;
    res = '0;
    n = stack_used;
    top_w = (n >= 1) ? stack_words[n-1] : '0;
    next_w = (n >= 2) ? stack_words[n-2] : '0;
    case (act)
      ACT_PUSH, ACT_IN: begin
        if (n >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_words[n] = val;
          stack_used = n + 1;
        end
      end
      ACT_PUSHR: begin
        if (int'(ri) >= NUM_REGS || !reg_valid[ri]) begin
          res.status = ST_NOREG;
        end else if (n >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_words[n] = reg_words[ri];
          stack_used = n + 1;
        end
      end
      ACT_POP: begin
        if (n < 1) res.status = ST_UNDER;
        else stack_used = n - 1;
      end
      ACT_POPR: begin
        if (n < 1) begin
          res.status = ST_UNDER;
        end else if (int'(ri) >= NUM_REGS) begin
          res.status = ST_NOREG;
        end else begin
          reg_words[ri] = top_w;
          reg_valid[ri] = 1'b1;
          stack_used = n - 1;
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
        if (n < 2) begin
          res.status = ST_UNDER;
        end else if (n >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else if (act == ACT_DIV && next_w == '0) begin
          res.status = ST_DIVZ;
        end else begin
          stack_words[n] = alu_result(act, top_w, next_w);
          stack_used = n + 1;
        end
      end
      ACT_OUT: begin
        if (n < 1) begin
          res.status = ST_UNDER;
        end else begin
          res.out_valid = 1'b1;
          res.out_value = top_w;
          stack_used = n - 1;
        end
      end
      ACT_JMP: res.branch_taken = 1'b1;
      ACT_JEQ, ACT_JNE, ACT_JA, ACT_JAE, ACT_JB, ACT_JBE: begin
        if (n < 2) res.status = ST_UNDER;
        else res.branch_taken = branch_cond(act, top_w, next_w);
      end
      default: ;
    endcase
    if (res.branch_taken) res.branch_target = tgt;
    res.stack_count = stack_used[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    smx_result_t want;
    if (!rst_ni) begin
      stack_used = 0;
      reg_valid = '0;
      exp_results_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        exp_results_q.push_back(execute_instr(action_i, value_i, reg_index_i,
                                              jump_target_i));
      end
      if (result_valid_i && result_ready_i) begin
        if (exp_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0h count %0h",
                   $time, status_i, stack_count_i);
          fail_count_o++;
        end else begin
          want = exp_results_q.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(status_i));
          check_field("out_valid", DATA_W'(want.out_valid), DATA_W'(out_valid_i));
          check_field("out_value", want.out_value, out_value_i);
          check_field("branch_taken", DATA_W'(want.branch_taken),
                      DATA_W'(branch_taken_i));
          check_field("branch_target", DATA_W'(want.branch_target),
                      DATA_W'(branch_target_i));
          check_field("stack_count", DATA_W'(want.stack_count),
                      DATA_W'(stack_count_i));
        end
      end
    end
    pending_o = exp_results_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the stack_machine_execute_unit regression: clock, reset, instruction
// stimulus, result back-pressure and verdict. Depends on smx_pkg, the unit
// under test and smx_exec_checker.
module tb_top;
  import smx_pkg::*;

  localparam int RAND_ITEMS  = 1700;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 60;

  typedef enum logic [1:0] {
    MIX_OPS,
    GROW_STACK,
    DRAIN_STACK
  } op_mix_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [ACTION_W-1:0]      action_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic [REG_IDX_W-1:0]     reg_index_i = '0;
  logic [TARGET_W-1:0]      jump_target_i = '0;
  logic                     result_valid_o;
  logic                     result_ready_i = 1'b1;
  logic [STATUS_W-1:0]      status_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic                     branch_taken_o;
  logic [TARGET_W-1:0]      branch_target_o;
  logic [COUNT_OUT_W-1:0]   stack_count_o;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   rx_hold = 0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stack_machine_execute_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .reg_index_i    (reg_index_i),
    .jump_target_i  (jump_target_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .status_o       (status_o),
    .out_valid_o    (out_valid_o),
    .out_value_o    (out_value_o),
    .branch_taken_o (branch_taken_o),
    .branch_target_o(branch_target_o),
    .stack_count_o  (stack_count_o)
  );

  smx_exec_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .reg_index_i    (reg_index_i),
    .jump_target_i  (jump_target_i),
    .result_valid_i (result_valid_o),
    .result_ready_i (result_ready_i),
    .status_i       (status_o),
    .out_valid_i    (out_valid_o),
    .out_value_i    (out_value_o),
    .branch_taken_i (branch_taken_o),
    .branch_target_i(branch_target_o),
    .stack_count_i  (stack_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic int draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // result side: after each transaction hold ready low for a drawn number of cycles
  always @(posedge clk_i) begin
    int wait_n;
    if (result_valid_o && result_ready_i) begin
      if ($urandom_range(0, 49) == 0) rx_burst <= !rx_burst;
      wait_n = draw_wait(rx_burst);
      rx_hold <= wait_n;
      if (wait_n != 0) result_ready_i <= 1'b0;
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_hold == 1) begin
      rx_hold <= 0;
      result_ready_i <= 1'b1;
    end else begin
      result_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (result_valid_o && result_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("stack_machine_execute_unit regression: fail");
    $finish;
  end

  task automatic send_instr(input logic [ACTION_W-1:0] act,
                            input logic [DATA_W-1:0] val,
                            input logic [REG_IDX_W-1:0] ri,
                            input logic [TARGET_W-1:0] tgt);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    value_i       <= val;
    reg_index_i   <= ri;
    jump_target_i <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [ACTION_W-1:0] pick_action(op_mix_e mix);
    int w_push;
    int w_pushr;
    int w_arith;
    int w_pop;
    int w_jump;
    int r;
    case (mix)
      GROW_STACK:  begin w_push = 55; w_pushr = 10; w_arith = 20; w_pop = 7;  w_jump = 6;  end
      DRAIN_STACK: begin w_push = 10; w_pushr = 5;  w_arith = 10; w_pop = 60; w_jump = 13; end
      default:     begin w_push = 20; w_pushr = 10; w_arith = 20; w_pop = 25; w_jump = 20; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_push) return $urandom_range(0, 1) ? ACT_PUSH : ACT_IN;
    r -= w_push;
    if (r < w_pushr) return ACT_PUSHR;
    r -= w_pushr;
    if (r < w_arith) return ACT_ADD + ACTION_W'($urandom_range(0, 3));
    r -= w_arith;
    if (r < w_pop) begin
      case ($urandom_range(0, 2))
        0:       return ACT_POP;
        1:       return ACT_POPR;
        default: return ACT_OUT;
      endcase
    end
    r -= w_pop;
    if (r < w_jump) return ACT_JMP + ACTION_W'($urandom_range(0, 6));
    return ACTION_W'($urandom_range(ACT_JBE + 1, 31));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    op_mix_e mix;
    int      seg_left;
    int      sent;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack and unwritten registers
    send_instr(ACT_POP, '0, '0, '0);
    send_instr(ACT_OUT, '0, '0, '0);
    send_instr(ACT_POPR, '0, 4'd3, '0);
    send_instr(ACT_PUSHR, '0, 4'd5, '0);
    send_instr(ACT_JMP, '0, '0, 16'hFFFF);
    send_instr(5'd31, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
    send_instr(ACT_PUSH, 32'h7FFF_FFFF, '0, '0);
    send_instr(ACT_JEQ, '0, '0, 16'h1234);
    // most negative divided by minus one
    send_instr(ACT_PUSH, 32'hFFFF_FFFF, '0, '0);
    send_instr(ACT_PUSH, 32'h8000_0000, '0, '0);
    send_instr(ACT_DIV, '0, '0, '0);
    send_instr(ACT_SUB, '0, '0, '0);
    send_instr(ACT_MUL, '0, '0, '0);
    send_instr(ACT_ADD, '0, '0, '0);
    // zero divisor, then signed compares of 7 against 0
    send_instr(ACT_PUSH, '0, '0, '0);
    send_instr(ACT_PUSH, 32'd7, '0, '0);
    send_instr(ACT_DIV, '0, '0, '0);
    send_instr(ACT_JA, '0, '0, 16'h0001);
    send_instr(ACT_JB, '0, '0, 16'h8000);
    send_instr(ACT_JAE, '0, '0, 16'hFFFE);
    send_instr(ACT_JBE, '0, '0, 16'h00FF);
    send_instr(ACT_JEQ, '0, '0, 16'h0F0F);
    send_instr(ACT_JNE, '0, '0, 16'hF0F0);
    send_instr(ACT_POPR, '0, 4'hF, '0);
    send_instr(ACT_PUSHR, '0, 4'hF, '0);
    send_instr(ACT_OUT, '0, '0, '0);
    send_instr(ACT_IN, 32'h1234_5678, '0, '0);

    // first segment fills the stack to capacity
    mix = GROW_STACK;
    seg_left = 450;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (seg_left == 0) begin
        mix = op_mix_e'($urandom_range(0, 2));
        seg_left = $urandom_range(60, 250);
      end
      send_instr(pick_action(mix), pick_value(), REG_IDX_W'($urandom_range(0, 15)),
                 TARGET_W'($urandom()));
      sent++;
      seg_left--;
    end
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("stack_machine_execute_unit regression: pass");
    else
      $display("stack_machine_execute_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/smx_pkg.sv
hdl/smx_front.sv
hdl/smx_queue.sv
hdl/smx_divider.sv
hdl/smx_back.sv
hdl/stack_machine_execute_unit.sv
tb/smx_exec_checker.sv
tb/tb_top.sv
